### rtl/core/led_pixel_clocked_serializer_defines.svh
// Assertion macros for the clocked LED pixel serializer.
// Used by the top level only; no other dependencies.
`ifndef LED_PIXEL_CLOCKED_SERIALIZER_DEFINES_SVH
`define LED_PIXEL_CLOCKED_SERIALIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LPCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpcs assertion failed");

// Next-cycle implication, checked out of reset.
`define LPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpcs assertion failed");

`endif

### rtl/core/lpcs_pkg.sv
// Types and constants for the clocked LED pixel serializer.
// No dependencies.
`timescale 1ns / 1ps

package lpcs_pkg;

    localparam int unsigned BITS_PER_PIXEL = 24;
    localparam int unsigned MAX_PIXELS     = 512;
    localparam int unsigned POS_W          = $clog2(MAX_PIXELS);
    localparam int unsigned CNT_W          = 10;
    localparam int unsigned BIT_W          = 5;
    localparam int unsigned TICK_W         = 16;
    localparam int unsigned WORD_W         = 24;

    localparam logic [BIT_W-1:0]  LAST_BIT_IDX = BIT_W'(BITS_PER_PIXEL - 1);
    localparam logic [CNT_W-1:0]  MAX_COUNT    = CNT_W'(MAX_PIXELS);

    localparam logic [TICK_W-1:0] BIT_PERIOD_RST = 16'd280;
    localparam logic [TICK_W-1:0] HOLD_RST       = 16'd4000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SEND   = 2'd1,
        PH_FINISH = 2'd2,
        PH_HOLD   = 2'd3
    } t_phase;

    localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [1:0] REG_HOLD       = 2'd1;
    localparam logic [1:0] REG_LSB_FIRST  = 2'd2;

    typedef struct packed {
        logic busy;
        logic data;
        logic clk;
    } t_result;

endpackage

### rtl/core/lpcs_skid.sv
// Two-entry output register with skid stage for result beats.
// Depends on lpcs_pkg.
`timescale 1ns / 1ps

module lpcs_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lpcs_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output lpcs_pkg::t_result o_data
);
    import lpcs_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_take;
    logic    w_push;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign w_take  = r_out_valid && i_ready;
    assign w_push  = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_push) begin
                if (!r_out_valid || w_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

### rtl/core/led_pixel_clocked_serializer.sv
// Clocked LED pixel serializer: pixel store, bit timing and line levels.
// Depends on lpcs_pkg, lpcs_skid and led_pixel_clocked_serializer_defines.svh.
//
//  channel | dir | handshake              | payload
//  s_*     | in  | s_tvalid / s_tready    | tuser op, tdata index/value/count
//  m_*     | out | m_tvalid / m_tready    | tdata clk, data, busy levels
//  apb     | in  | psel & penable & pwrite| bit period, hold, bit order
//
// One beat per cycle while s_tready is high: each input beat yields one
// result beat. The pixel word is prefetched from the store into a
// register, so bit events never wait on the read.
// Synchronous active-low reset clears control; the store is not cleared.
// s_tready drops only while both output register and skid stage are full.
`timescale 1ns / 1ps
`include "led_pixel_clocked_serializer_defines.svh"

module led_pixel_clocked_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pixel_index[8:0], pixel_value[32:9], pixel_count[42:33]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // clk_out[0], data_out[1], busy_res[2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lpcs_pkg::*;

    // config
    logic [TICK_W-1:0] r_bit_period;
    logic [TICK_W-1:0] r_hold;
    logic              r_lsb_first;
    logic              w_cfg_wr;

    // state
    t_phase            r_phase, n_phase;
    logic [POS_W-1:0]  r_read_pos, n_read_pos;
    logic [CNT_W-1:0]  r_remaining, n_remaining;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [TICK_W-1:0] r_countdown, n_countdown;
    logic              r_rise_pend, n_rise_pend;
    logic              r_clk, n_clk;
    logic              r_data, n_data;

    // store
    logic [WORD_W-1:0] r_store [MAX_PIXELS];
    logic [WORD_W-1:0] r_word;

    // decode
    logic              w_acc;
    t_op               w_op;
    logic [POS_W-1:0]  w_idx;
    logic [WORD_W-1:0] w_val;
    logic [CNT_W-1:0]  w_cnt;
    logic              w_load;
    logic              w_start;
    logic              w_tick;
    logic              w_expire;
    logic              w_last_bit;
    logic [CNT_W-1:0]  w_rem_dec;
    logic [BIT_W-1:0]  w_first_bit;
    logic [31:0]       w_word_ext;
    t_result           w_result;
    logic              w_out_ready;
    t_result           w_out;

    assign w_acc       = s_tvalid && s_tready;
    assign w_op        = t_op'(s_tuser);
    assign w_idx       = s_tdata[8:0];
    assign w_val       = s_tdata[32:9];
    assign w_cnt       = s_tdata[42:33];
    assign w_load      = w_acc && (w_op == OP_LOAD) && (r_phase == PH_IDLE);
    assign w_start     = w_acc && (w_op == OP_START) && (r_phase == PH_IDLE)
                         && (w_cnt != '0);
    assign w_tick      = w_acc && (w_op == OP_TICK);
    assign w_expire    = w_tick && !r_rise_pend && (r_phase != PH_IDLE)
                         && (r_countdown <= TICK_W'(1));
    assign w_first_bit = r_lsb_first ? '0 : LAST_BIT_IDX;
    assign w_last_bit  = r_lsb_first ? (r_bit >= LAST_BIT_IDX) : (r_bit == '0);
    assign w_rem_dec   = r_remaining - CNT_W'(1);
    assign w_word_ext  = {{(32-WORD_W){1'b0}}, r_word};

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (w_start) begin
                    n_phase = PH_SEND;
                end
            end
            PH_SEND: begin
                if (w_expire && w_last_bit && (w_rem_dec == '0)) begin
                    n_phase = PH_FINISH;
                end
            end
            PH_FINISH: begin
                if (w_expire) begin
                    n_phase = PH_HOLD;
                end
            end
            PH_HOLD: begin
                if (w_expire) begin
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_read_pos  = r_read_pos;
        n_remaining = r_remaining;
        n_bit       = r_bit;
        n_countdown = r_countdown;
        n_rise_pend = r_rise_pend;
        n_clk       = r_clk;
        n_data      = r_data;
        if (w_start) begin
            n_remaining = (w_cnt > MAX_COUNT) ? MAX_COUNT : w_cnt;
            n_read_pos  = '0;
            n_bit       = w_first_bit;
            n_countdown = r_bit_period;
            n_rise_pend = 1'b0;
        end else if (w_tick && r_rise_pend) begin
            n_clk       = 1'b1;
            n_rise_pend = 1'b0;
            n_countdown = (r_countdown > TICK_W'(1)) ? r_countdown - TICK_W'(1)
                                                     : TICK_W'(1);
        end else if (w_tick && (r_phase != PH_IDLE)) begin
            if (!w_expire) begin
                n_countdown = r_countdown - TICK_W'(1);
            end else begin
                case (r_phase)
                    PH_SEND: begin
                        n_clk       = 1'b0;
                        n_data      = (r_bit < BIT_W'(WORD_W)) ? w_word_ext[r_bit] : 1'b0;
                        n_rise_pend = 1'b1;
                        n_countdown = r_bit_period;
                        if (!w_last_bit) begin
                            n_bit = r_lsb_first ? r_bit + BIT_W'(1) : r_bit - BIT_W'(1);
                        end else begin
                            n_remaining = w_rem_dec;
                            if (w_rem_dec != '0) begin
                                n_read_pos = r_read_pos + POS_W'(1);
                                n_bit      = w_first_bit;
                            end
                        end
                    end
                    PH_FINISH: begin
                        n_clk       = 1'b0;
                        n_data      = 1'b0;
                        n_countdown = r_hold;
                    end
                    PH_HOLD: begin
                        n_countdown = '0;
                    end
                    default: n_countdown = r_countdown;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_read_pos  <= '0;
            r_remaining <= '0;
            r_bit       <= '0;
            r_countdown <= '0;
            r_rise_pend <= 1'b0;
            r_clk       <= 1'b0;
            r_data      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_read_pos  <= n_read_pos;
            r_remaining <= n_remaining;
            r_bit       <= n_bit;
            r_countdown <= n_countdown;
            r_rise_pend <= n_rise_pend;
            r_clk       <= n_clk;
            r_data      <= n_data;
        end
    end

    // pixel store: prefetch word at the next read position, forward same-entry load
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_store[w_idx] <= w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && (w_idx == n_read_pos)) begin
            r_word <= w_val;
        end else begin
            r_word <= r_store[n_read_pos];
        end
    end

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BIT_PERIOD_RST;
            r_hold       <= HOLD_RST;
            r_lsb_first  <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_BIT_PERIOD: r_bit_period <= pwdata[TICK_W-1:0];
                REG_HOLD:       r_hold       <= pwdata[TICK_W-1:0];
                REG_LSB_FIRST:  r_lsb_first  <= pwdata[0];
                default:        r_lsb_first  <= r_lsb_first;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BIT_PERIOD: prdata = {{(32-TICK_W){1'b0}}, r_bit_period};
            REG_HOLD:       prdata = {{(32-TICK_W){1'b0}}, r_hold};
            REG_LSB_FIRST:  prdata = {31'd0, r_lsb_first};
            default:        prdata = '0;
        endcase
    end

    // result beat
    always_comb begin
        w_result.clk  = n_clk;
        w_result.data = n_data;
        w_result.busy = (n_phase != PH_IDLE);
    end

    lpcs_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .o_ready (w_out_ready),
        .i_data  (w_result),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (w_out)
    );

    assign s_tready = w_out_ready;
    assign m_tdata  = {5'd0, w_out};

    `LPCS_ASSERT_NOW(a_idle_lines_low, i_clk, i_rst_n, r_phase == PH_IDLE, !r_rise_pend && !r_clk)
    `LPCS_ASSERT_NOW(a_send_has_pixels, i_clk, i_rst_n, r_phase == PH_SEND, r_remaining != '0)
    `LPCS_ASSERT_NEXT(a_start_enters_send, i_clk, i_rst_n, w_start, r_phase == PH_SEND)

endmodule
